// ===== rtl/core/ccw_pkg.sv =====
package ccw_pkg;

	localparam int MaxAmount = 1023;
	localparam int Depth = MaxAmount + 1;
	localparam int AddrW = $clog2(Depth);
	localparam int CoinW = 10;
	localparam int TargetW = 10;
	localparam int CountW = 32;
	localparam int DataW = 32;
	localparam int PaddrW = 3;
	localparam int InDataW = 16;
	localparam int QueueDepth = 2;
	localparam int QPtrW = 1;

	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
	localparam logic [AddrW-1:0] LastEntry = AddrW'(MaxAmount);
	localparam logic [PaddrW-1:0] CfgTargetAddr = PaddrW'(0);

	typedef struct packed {
		logic [AddrW-1:0] coin;
		logic [AddrW-1:0] target;
		logic last;
		logic skip;
	} item_t;

	typedef enum logic [2:0] {
		StIdle,
		StSweep,
		StDrain,
		StRdout,
		StEmit,
		StClear
	} state_t;

endpackage

// ===== rtl/core/ccw_ram.sv =====
module ccw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== rtl/core/ccw_front.sv =====
module ccw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ccw_pkg::CoinW-1:0]     coin_value,
	input  logic                          last_coin,
	input  logic [ccw_pkg::TargetW-1:0]   target,
	input  logic                          clearing,
	output logic                          item_valid,
	output ccw_pkg::item_t                item,
	input  logic                          item_pop
);

	ccw_pkg::item_t new_item;
	ccw_pkg::item_t queue_q [ccw_pkg::QueueDepth];
	logic [ccw_pkg::QPtrW-1:0] wr_ptr_q;
	logic [ccw_pkg::QPtrW-1:0] rd_ptr_q;
	logic [ccw_pkg::QPtrW:0] count_q;
	logic [ccw_pkg::AddrW-1:0] eff_target;
	logic push;

	// A target beyond the table is clamped to its last entry.
	always_comb begin
		if (int'(target) > ccw_pkg::MaxAmount) begin
			eff_target = ccw_pkg::LastEntry;
		end else begin
			eff_target = ccw_pkg::AddrW'(target);
		end
		new_item.coin = ccw_pkg::AddrW'(coin_value);
		new_item.target = eff_target;
		new_item.last = last_coin;
		new_item.skip = (coin_value == '0) || (int'(coin_value) > int'(eff_target));
	end

	assign in_ready = (count_q != (ccw_pkg::QPtrW+1)'(ccw_pkg::QueueDepth)) && !clearing;
	assign push = in_valid && in_ready;
	assign item_valid = (count_q != '0);
	assign item = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ccw_pkg::QPtrW'(1);
			end
			if (item_pop) begin
				rd_ptr_q <= rd_ptr_q + ccw_pkg::QPtrW'(1);
			end
			if (push && !item_pop) begin
				count_q <= count_q + (ccw_pkg::QPtrW+1)'(1);
			end else if (!push && item_pop) begin
				count_q <= count_q - (ccw_pkg::QPtrW+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/core/ccw_back.sv =====
module ccw_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  ccw_pkg::item_t              item,
	output logic                        item_pop,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ccw_pkg::CountW-1:0]  way_count,
	output logic                        saturated
);

	ccw_pkg::state_t state_q;
	ccw_pkg::state_t state_d;

	logic [ccw_pkg::AddrW-1:0] coin_q;
	logic [ccw_pkg::AddrW-1:0] target_q;
	logic [ccw_pkg::AddrW-1:0] j_q;
	logic [ccw_pkg::AddrW-1:0] clr_cnt_q;
	logic last_q;
	logic sat_q;
	logic [ccw_pkg::CountW-1:0] prev_q;

	logic wr_valid_s1;
	logic [ccw_pkg::AddrW-1:0] wr_addr_s1;
	logic zero_s1;
	logic fwd_s1;

	logic issue;
	logic load_out;
	logic clr;
	logic [ccw_pkg::AddrW-1:0] raddr_a;
	logic [ccw_pkg::AddrW-1:0] raddr_b;
	logic [ccw_pkg::CountW-1:0] rdata_a;
	logic [ccw_pkg::CountW-1:0] rdata_b;
	logic [ccw_pkg::CountW-1:0] lower_val;
	logic [ccw_pkg::CountW:0] sum;
	logic [ccw_pkg::CountW-1:0] sum_sat;
	logic we;
	logic [ccw_pkg::AddrW-1:0] waddr;
	logic [ccw_pkg::CountW-1:0] wdata;

	ccw_ram #(
		.WIDTH(ccw_pkg::CountW),
		.DEPTH(ccw_pkg::Depth)
	) u_table (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	// Entry zero always reads as one. With a coin of one, the lower entry is the
	// one written in the previous cycle, so it is taken from the forward register.
	always_comb begin
		if (zero_s1) begin
			lower_val = ccw_pkg::CountW'(1);
		end else if (fwd_s1) begin
			lower_val = prev_q;
		end else begin
			lower_val = rdata_b;
		end
		sum = {1'b0, rdata_a} + {1'b0, lower_val};
		sum_sat = sum[ccw_pkg::CountW] ? ccw_pkg::CountMax : sum[ccw_pkg::CountW-1:0];
	end

	assign we = wr_valid_s1 || clr;
	assign waddr = clr ? clr_cnt_q : wr_addr_s1;
	assign wdata = clr ? '0 : sum_sat;
	assign clearing = (state_q == ccw_pkg::StClear);

	always_comb begin
		state_d = state_q;
		item_pop = 1'b0;
		issue = 1'b0;
		load_out = 1'b0;
		clr = 1'b0;
		raddr_a = j_q;
		raddr_b = j_q - coin_q;
		unique case (state_q)
			ccw_pkg::StIdle: begin
				if (item_valid) begin
					item_pop = 1'b1;
					if (!item.skip) begin
						state_d = ccw_pkg::StSweep;
					end else if (item.last) begin
						state_d = ccw_pkg::StRdout;
					end
				end
			end
			ccw_pkg::StSweep: begin
				issue = 1'b1;
				if (j_q == target_q) begin
					state_d = ccw_pkg::StDrain;
				end
			end
			ccw_pkg::StDrain: begin
				state_d = last_q ? ccw_pkg::StRdout : ccw_pkg::StIdle;
			end
			ccw_pkg::StRdout: begin
				raddr_a = target_q;
				state_d = ccw_pkg::StEmit;
			end
			ccw_pkg::StEmit: begin
				raddr_a = target_q;
				if (!out_valid || out_ready) begin
					load_out = 1'b1;
					state_d = ccw_pkg::StClear;
				end
			end
			ccw_pkg::StClear: begin
				clr = 1'b1;
				if (clr_cnt_q == ccw_pkg::LastEntry) begin
					state_d = ccw_pkg::StIdle;
				end
			end
			default: begin
				state_d = ccw_pkg::StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccw_pkg::StClear;
			clr_cnt_q <= '0;
			wr_valid_s1 <= 1'b0;
			sat_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_valid_s1 <= issue;
			if (clr) begin
				clr_cnt_q <= clr_cnt_q + ccw_pkg::AddrW'(1);
			end else begin
				clr_cnt_q <= '0;
			end
			if (load_out) begin
				sat_q <= 1'b0;
			end else if (wr_valid_s1 && sum[ccw_pkg::CountW]) begin
				sat_q <= 1'b1;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			coin_q <= item.coin;
			target_q <= item.target;
			last_q <= item.last;
			j_q <= item.coin;
		end else if (issue) begin
			j_q <= j_q + ccw_pkg::AddrW'(1);
		end
		if (issue) begin
			wr_addr_s1 <= j_q;
			zero_s1 <= (j_q == coin_q);
			fwd_s1 <= (coin_q == ccw_pkg::AddrW'(1)) && (j_q != coin_q);
		end
		if (wr_valid_s1) begin
			prev_q <= sum_sat;
		end
		if (load_out) begin
			way_count <= (target_q == '0) ? ccw_pkg::CountW'(1) : rdata_a;
			saturated <= sat_q;
		end
	end

endmodule

// ===== rtl/core/coin_change_way_counter.sv =====
// Channel      Dir  Handshake                      Contents
// s_axis       in   s_axis_tvalid / s_axis_tready  tdata[9:0] coin_value, tlast last_coin
// m_axis       out  m_axis_tvalid / m_axis_tready  tdata[31:0] way_count, tuser saturated
// apb          in   psel, penable, pwrite, pready  byte address 0: target_amount[9:0]
//
// A coin request sweeps the table from the coin up to the target in the back end, one
// entry per cycle through the two-read, one-write table memory; a zero coin or one above
// the target skips it. The request that closes a set then reads the count out, and a
// clearing pass rewrites the table. The same pass runs after reset, and no request is
// taken while it runs. A two-entry queue takes requests while the back end works, and
// the output register holds a result until it is taken while the clearing pass goes on.
module coin_change_way_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ccw_pkg::InDataW-1:0]   s_axis_tdata,  // [9:0] coin_value
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [ccw_pkg::CountW-1:0]    m_axis_tdata,  // [31:0] way_count
	output logic                          m_axis_tuser,  // [0] saturated
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ccw_pkg::PaddrW-1:0]    paddr,
	input  logic [ccw_pkg::DataW-1:0]     pwdata,
	output logic [ccw_pkg::DataW-1:0]     prdata,
	output logic                          pready
);

	logic [ccw_pkg::TargetW-1:0] target_q;
	logic item_valid;
	logic item_pop;
	logic clearing;
	ccw_pkg::item_t item;

	assign pready = 1'b1;
	assign prdata = (paddr == ccw_pkg::CfgTargetAddr) ?
		ccw_pkg::DataW'(target_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == ccw_pkg::CfgTargetAddr)) begin
			target_q <= pwdata[ccw_pkg::TargetW-1:0];
		end
	end

	ccw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.coin_value(s_axis_tdata[ccw_pkg::CoinW-1:0]),
		.last_coin (s_axis_tlast),
		.target    (target_q),
		.clearing  (clearing),
		.item_valid(item_valid),
		.item      (item),
		.item_pop  (item_pop)
	);

	ccw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.item_pop  (item_pop),
		.clearing  (clearing),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.way_count (m_axis_tdata),
		.saturated (m_axis_tuser)
	);

endmodule
